// ===== src/prts_pkg.sv =====
// shared types and constants for the periodic task release scheduler
// used by the front end, the back end and the top level
// no dependencies

package prts_pkg;

	// parameter defaults
	localparam int TASK_SLOTS_DEF = 8;
	localparam int TIME_BITS_DEF  = 32;
	localparam int QUEUE_DEPTH    = 2;

	// field widths
	localparam int OP_W    = 3;
	localparam int IDX_W   = 4;
	localparam int PRIO_W  = 16;
	localparam int PEND_W  = 16;
	localparam int FIELD_W = 32;
	localparam int REL_W   = 4;
	localparam int TOTAL_W = 32;
	localparam int REL_MAX = 15;

	// input tdata layout, lowest bit first
	localparam int IN_NOW_LO   = 0;
	localparam int IN_IDX_LO   = IN_NOW_LO + FIELD_W;
	localparam int IN_VALID_LO = IN_IDX_LO + IDX_W;
	localparam int IN_PER_LO   = IN_VALID_LO + 1;
	localparam int IN_PRIO_LO  = IN_PER_LO + FIELD_W;
	localparam int IN_FIRST_LO = IN_PRIO_LO + PRIO_W;
	localparam int IN_FIELDS_W = IN_FIRST_LO + FIELD_W;
	localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

	// output tdata layout
	localparam int OUT_FIELDS_W = IDX_W + 1 + REL_W + 1 + TOTAL_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	// operation codes carried in tuser
	localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
	localparam logic [OP_W-1:0] OP_SCHEDULE = 3'd1;
	localparam logic [OP_W-1:0] OP_WRITE    = 3'd2;
	localparam logic [OP_W-1:0] OP_DONE     = 3'd3;
	localparam logic [OP_W-1:0] OP_SWITCH   = 3'd4;

	// command kind after classification; ignored items become no-ops
	typedef enum logic [2:0] {
		KIND_TICK   = 3'd0,
		KIND_SCHED  = 3'd1,
		KIND_WRITE  = 3'd2,
		KIND_DONE   = 3'd3,
		KIND_SWITCH = 3'd4,
		KIND_NOP    = 3'd5
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [IDX_W-1:0]  task_index;
	} cmd_ctl_t;

endpackage

// ===== src/prts_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies

module prts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic                                  rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/prts_front.sv =====
// front end: accepts items, unpacks them and classifies them into commands
// depends on prts_pkg

module prts_front #(
	parameter int TASK_SLOTS = prts_pkg::TASK_SLOTS_DEF,
	parameter int TIME_BITS  = prts_pkg::TIME_BITS_DEF
) (
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [prts_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic [prts_pkg::OP_W-1:0]         s_tuser,
	input  logic                              q_full,
	output logic                              q_push,
	output prts_pkg::cmd_ctl_t                q_ctl,
	output logic [2*TIME_BITS+prts_pkg::PRIO_W:0] q_pay
);

	import prts_pkg::*;

	logic [FIELD_W-1:0] now;
	logic [IDX_W-1:0]   idx;
	logic               entry_valid;
	logic [FIELD_W-1:0] entry_period;
	logic [PRIO_W-1:0]  entry_priority;
	logic [FIELD_W-1:0] entry_first;
	logic               slot_ok;
	logic               switch_ok;
	kind_t              kind;
	logic [TIME_BITS-1:0] pay_time;

	// unpack the item
	assign now            = s_tdata[IN_NOW_LO +: FIELD_W];
	assign idx            = s_tdata[IN_IDX_LO +: IDX_W];
	assign entry_valid    = s_tdata[IN_VALID_LO];
	assign entry_period   = s_tdata[IN_PER_LO +: FIELD_W];
	assign entry_priority = s_tdata[IN_PRIO_LO +: PRIO_W];
	assign entry_first    = s_tdata[IN_FIRST_LO +: FIELD_W];

	// task number range checks
	assign slot_ok   = (idx != '0) && (32'(idx) <= 32'(TASK_SLOTS));
	assign switch_ok = 32'(idx) <= 32'(TASK_SLOTS);

	// classify; out-of-range writes, job-dones and switches turn into no-ops
	always_comb begin
		unique case (s_tuser)
			OP_TICK:     kind = KIND_TICK;
			OP_SCHEDULE: kind = KIND_SCHED;
			OP_WRITE:    kind = slot_ok ? KIND_WRITE : KIND_NOP;
			OP_DONE:     kind = slot_ok ? KIND_DONE : KIND_NOP;
			OP_SWITCH:   kind = switch_ok ? KIND_SWITCH : KIND_NOP;
			default:     kind = KIND_NOP;
		endcase
	end

	// a tick carries the time, a write carries its first release
	assign pay_time = (kind == KIND_TICK) ? TIME_BITS'(now) : TIME_BITS'(entry_first);

	assign q_ctl.kind       = kind;
	assign q_ctl.task_index = idx;
	assign q_pay = {entry_valid, entry_priority, TIME_BITS'(entry_period), pay_time};

	// handshake into the queue
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

endmodule

// ===== src/prts_fifo.sv =====
// short command queue between the front end and the back end
// no dependencies

module prts_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = count_q == CW'(DEPTH);
	assign not_empty = count_q != '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = store_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== src/prts_back.sv =====
// back end: task table in ram, slot scan sequencer and result register
// depends on prts_pkg and prts_ram

module prts_back #(
	parameter int TASK_SLOTS = prts_pkg::TASK_SLOTS_DEF,
	parameter int TIME_BITS  = prts_pkg::TIME_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  q_valid,
	input  prts_pkg::cmd_ctl_t                    q_ctl,
	input  logic [2*TIME_BITS+prts_pkg::PRIO_W:0] q_pay,
	output logic                                  q_pop,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [prts_pkg::OUT_DATA_W-1:0]       m_tdata
);

	import prts_pkg::*;

	localparam int SLOT_W  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int CNT_W   = $clog2(TASK_SLOTS + 1);
	localparam int ROW_W   = 2 * TIME_BITS + PRIO_W + PEND_W;
	localparam int PRIO_LO = PEND_W;
	localparam int REL_LO  = PEND_W + PRIO_W;
	localparam int PER_LO  = REL_LO + TIME_BITS;
	localparam int PAD_W   = OUT_DATA_W - OUT_FIELDS_W;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t                state_q;
	kind_t                 kind_q;
	logic [TIME_BITS-1:0]  now_q;
	logic                  proc_s1;
	logic [SLOT_W-1:0]     slot_s1;
	logic                  last_s1;
	logic [TASK_SLOTS-1:0] valid_q;
	logic [CNT_W-1:0]      count_q;
	logic                  found_q;
	logic [SLOT_W-1:0]     best_q;
	logic [PRIO_W-1:0]     best_prio_q;
	logic [IDX_W-1:0]      running_q;
	logic [TOTAL_W-1:0]    total_q;
	logic                  resched_q;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// queue head fields
	logic [TIME_BITS-1:0] pay_time;
	logic [TIME_BITS-1:0] pay_period;
	logic [PRIO_W-1:0]    pay_prio;
	logic                 pay_valid;
	logic [SLOT_W-1:0]    q_slot;

	// ram ports
	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr;
	logic [ROW_W-1:0]  ram_wdata;
	logic              ram_re;
	logic [SLOT_W-1:0] ram_raddr;
	logic [ROW_W-1:0]  ram_rdata;

	// row being processed
	logic [PEND_W-1:0]    row_pend;
	logic [PRIO_W-1:0]    row_prio;
	logic [TIME_BITS-1:0] row_rel;
	logic [TIME_BITS-1:0] row_per;
	logic                 row_live;
	logic [TIME_BITS-1:0] age;

	logic              out_free;
	logic              start_scan;
	logic              in_scan;
	logic              finish_scan;
	logic              finish_now;
	logic              out_load;
	logic              tick_hit;
	logic              done_hit;
	logic              cand;
	logic [CNT_W-1:0]  count_d;
	logic [TOTAL_W-1:0] total_d;
	logic              resched_d;
	logic              found_d;
	logic [SLOT_W-1:0] best_d;
	logic [IDX_W-1:0]  res_chosen;
	logic              res_switch;
	logic [REL_W-1:0]  res_released;

	assign pay_time   = q_pay[TIME_BITS-1:0];
	assign pay_period = q_pay[2*TIME_BITS-1:TIME_BITS];
	assign pay_prio   = q_pay[2*TIME_BITS +: PRIO_W];
	assign pay_valid  = q_pay[2*TIME_BITS+PRIO_W];
	assign q_slot     = SLOT_W'(q_ctl.task_index - IDX_W'(1));

	assign row_pend = ram_rdata[PEND_W-1:0];
	assign row_prio = ram_rdata[PRIO_LO +: PRIO_W];
	assign row_rel  = ram_rdata[REL_LO +: TIME_BITS];
	assign row_per  = ram_rdata[PER_LO +: TIME_BITS];
	// an inactive slot never holds pending jobs, so its row is not looked at
	assign row_live = valid_q[slot_s1];
	assign age      = now_q - row_rel;

	// sequencing
	assign out_free    = !out_valid_q || m_tready;
	assign q_pop       = (state_q == ST_IDLE) && q_valid && out_free;
	assign start_scan  = q_pop && ((q_ctl.kind == KIND_TICK) || (q_ctl.kind == KIND_SCHED) ||
		(q_ctl.kind == KIND_DONE));
	assign in_scan     = (state_q == ST_SCAN) && proc_s1;
	assign finish_scan = in_scan && last_s1;
	assign finish_now  = q_pop && !start_scan;
	assign out_load    = finish_scan || finish_now;

	// per-slot decisions
	assign tick_hit = in_scan && (kind_q == KIND_TICK) && row_live && !age[TIME_BITS-1];
	assign done_hit = in_scan && (kind_q == KIND_DONE) && row_live && (row_pend != '0);
	assign cand     = in_scan && (kind_q == KIND_SCHED) && row_live && (row_pend != '0) &&
		(!found_q || (row_prio < best_prio_q));

	// running results including the slot in flight
	assign count_d   = tick_hit ? count_q + 1'b1 : count_q;
	assign total_d   = tick_hit ? total_q + 1'b1 : total_q;
	assign resched_d = tick_hit ? 1'b1 :
		((finish_scan && (kind_q == KIND_SCHED)) ? 1'b0 : resched_q);
	assign found_d   = found_q || cand;
	assign best_d    = cand ? slot_s1 : best_q;

	// result fields; only a finished scan carries nonzero ones
	always_comb begin
		res_chosen   = '0;
		res_switch   = 1'b0;
		res_released = '0;
		if (finish_scan && (kind_q == KIND_SCHED)) begin
			res_chosen = found_d ? IDX_W'(best_d) + IDX_W'(1) : '0;
			res_switch = res_chosen != running_q;
		end
		if (finish_scan && (kind_q == KIND_TICK)) begin
			res_released = (32'(count_d) > 32'(REL_MAX)) ? REL_W'(REL_MAX) : REL_W'(count_d);
		end
	end

	// ram read: first slot on entry (the named slot for a job done), then the slot after the one in flight
	assign ram_re    = start_scan || (in_scan && !last_s1);
	assign ram_raddr = (state_q == ST_IDLE) ? ((q_ctl.kind == KIND_DONE) ? q_slot : '0) :
		slot_s1 + 1'b1;

	// ram write: entry load from the queue head, or write-back of the slot in flight
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_s1;
		ram_wdata = {row_per, row_rel, row_prio, row_pend};
		if (q_pop && (q_ctl.kind == KIND_WRITE)) begin
			ram_we    = 1'b1;
			ram_waddr = q_slot;
			ram_wdata = {pay_period, pay_time, pay_prio, {PEND_W{1'b0}}};
		end else if (tick_hit) begin
			ram_we    = 1'b1;
			ram_wdata = {row_per, row_rel + row_per, row_prio,
				(row_pend == '1) ? row_pend : row_pend + 1'b1};
		end else if (done_hit) begin
			ram_we    = 1'b1;
			ram_wdata = {row_per, row_rel, row_prio, row_pend - 1'b1};
		end
	end

	prts_ram #(
		.WIDTH(ROW_W),
		.DEPTH(TASK_SLOTS)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// state, scan pipeline and task table control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= KIND_NOP;
			proc_s1     <= 1'b0;
			slot_s1     <= '0;
			last_s1     <= 1'b0;
			valid_q     <= '0;
			count_q     <= '0;
			found_q     <= 1'b0;
			best_q      <= '0;
			running_q   <= '0;
			total_q     <= '0;
			resched_q   <= 1'b0;
		end else begin
			proc_s1   <= ram_re;
			slot_s1   <= ram_raddr;
			last_s1   <= ram_re && (((state_q == ST_IDLE) && (q_ctl.kind == KIND_DONE)) ||
				(ram_raddr == LAST_SLOT));
			total_q   <= total_d;
			resched_q <= resched_d;
			if (start_scan) begin
				state_q <= ST_SCAN;
				kind_q  <= q_ctl.kind;
				count_q <= '0;
				found_q <= 1'b0;
			end else begin
				if (finish_scan) begin
					state_q <= ST_IDLE;
				end
				count_q <= count_d;
				found_q <= found_d;
				best_q  <= best_d;
			end
			if (q_pop && (q_ctl.kind == KIND_WRITE)) begin
				valid_q[q_slot] <= pay_valid;
			end
			if (q_pop && (q_ctl.kind == KIND_SWITCH)) begin
				running_q <= q_ctl.task_index;
			end
		end
	end

	// scan payload
	always_ff @(posedge clk) begin
		if (start_scan) begin
			now_q <= pay_time;
		end
		if (cand) begin
			best_prio_q <= row_prio;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {{PAD_W{1'b0}}, total_d, resched_d, res_released, res_switch,
				res_chosen};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// a slot is in flight on every scan cycle
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> proc_s1)
		else $error("scan state without a slot in flight");

	// the result register is empty for the whole scan
	a_scan_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> !out_valid_q)
		else $error("result register occupied during a scan");

	// the last slot ends the scan and stops the read pipeline
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		finish_scan |=> (state_q == ST_IDLE) && !proc_s1)
		else $error("scan did not end after its last slot");

	// release count cannot exceed the number of slots
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(TASK_SLOTS))
		else $error("release count out of range");

endmodule

// ===== src/periodic_task_release_scheduler.sv =====
// top level of the periodic task release scheduler
// depends on prts_pkg, prts_front, prts_fifo and prts_back
//
//  channel   direction  signals                              accepted when
//  s_        in         s_tvalid s_tready s_tdata s_tuser    s_tvalid & s_tready
//  m_        out        m_tvalid m_tready m_tdata            m_tvalid & m_tready
//
// tick and schedule items walk the whole task table one slot per cycle through the
// table ram; job done visits only its own slot, the rest visit no slot.
// every item passes through the command queue (2 deep) first.
// until full, the queue takes items while the back end scans or the result waits.
// reset clears valid flags, running task, total and flag; entry fields,
// pending counts included, stay undefined until a write loads them.

module periodic_task_release_scheduler #(
	parameter int TASK_SLOTS = prts_pkg::TASK_SLOTS_DEF,
	parameter int TIME_BITS  = prts_pkg::TIME_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// now, task_index, entry_valid, entry_period, entry_priority, entry_first_release
	input  logic [prts_pkg::IN_DATA_W-1:0]  s_tdata,
	// operation
	input  logic [prts_pkg::OP_W-1:0]       s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// chosen_task, switch_needed, released_now, reschedule_request, total_releases
	output logic [prts_pkg::OUT_DATA_W-1:0] m_tdata
);

	import prts_pkg::*;

	localparam int PAY_W = 2 * TIME_BITS + PRIO_W + 1;
	localparam int CMD_W = $bits(cmd_ctl_t) + PAY_W;

	logic             push;
	logic             full;
	cmd_ctl_t         push_ctl;
	logic [PAY_W-1:0] push_pay;
	logic             pop;
	logic             not_empty;
	logic [CMD_W-1:0] head;
	cmd_ctl_t         head_ctl;
	logic [PAY_W-1:0] head_pay;

	// accept and classify
	prts_front #(
		.TASK_SLOTS(TASK_SLOTS),
		.TIME_BITS (TIME_BITS)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (full),
		.q_push   (push),
		.q_ctl    (push_ctl),
		.q_pay    (push_pay)
	);

	// command queue
	prts_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_ctl, push_pay}),
		.full      (full),
		.pop       (pop),
		.pop_data  (head),
		.not_empty (not_empty)
	);

	assign head_ctl = head[CMD_W-1:PAY_W];
	assign head_pay = head[PAY_W-1:0];

	// execute and deliver results
	prts_back #(
		.TASK_SLOTS(TASK_SLOTS),
		.TIME_BITS (TIME_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (not_empty),
		.q_ctl    (head_ctl),
		.q_pay    (head_pay),
		.q_pop    (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
